[rtl/core/nsa_pkg.sv]
`timescale 1ns / 1ps

package nsa_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned OP_W     = 2;

   // Blocks are kept in 32-byte granules.
   localparam logic [4:0] ALIGN_MASK = 5'h1F;

   localparam logic [WORD_W-1:0] CAP_RESET = 32'h0001_0000;
   localparam logic [WORD_W-1:0] WORD_MAX  = 32'hFFFF_FFFF;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_GROW  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_MISMATCH = 3'd3,
      ST_BUSY     = 3'd4
   } status_type;

   // Control from the allocator core to the entry stack.
   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctrl_type;

endpackage

[rtl/core/nsa_if.sv]
`timescale 1ns / 1ps

interface nsa_req_if #(
   parameter int unsigned SIZE_BITS = 25
);
   logic                            valid;
   logic                            ready;
   logic [nsa_pkg::OP_W-1:0]        operation;
   logic [SIZE_BITS-1:0]            request_size;
   logic [nsa_pkg::WORD_W-1:0]      release_offset;

   modport source (output valid, output operation, output request_size,
                   output release_offset, input ready);
   modport sink   (input valid, input operation, input request_size,
                   input release_offset, output ready);
endinterface

interface nsa_rsp_if #(
   parameter int unsigned SIZE_BITS = 25
);
   logic                            valid;
   logic                            ready;
   logic [nsa_pkg::STATUS_W-1:0]    status;
   logic [nsa_pkg::WORD_W-1:0]      offset;
   logic                            spilled;
   logic [SIZE_BITS-1:0]            block_size;
   logic [nsa_pkg::WORD_W-1:0]      total_allocated;
   logic [nsa_pkg::WORD_W-1:0]      peak_allocated;
   logic [nsa_pkg::WORD_W-1:0]      current_capacity;

   modport source (output valid, output status, output offset, output spilled,
                   output block_size, output total_allocated, output peak_allocated,
                   output current_capacity, input ready);
   modport sink   (input valid, input status, input offset, input spilled,
                   input block_size, input total_allocated, input peak_allocated,
                   input current_capacity, output ready);
endinterface

interface nsa_csr_if;
   logic                            valid;
   logic                            ready;
   logic [nsa_pkg::WORD_W-1:0]      initial_capacity;

   modport source (output valid, output initial_capacity, input ready);
   modport sink   (input valid, input initial_capacity, output ready);
endinterface

[rtl/core/nsa_entry_stack.sv]
`timescale 1ns / 1ps

// LIFO of entries with the top entry always available from a register.
module nsa_entry_stack #(
   parameter int unsigned DEPTH   = 32,
   parameter int unsigned ENTRY_W = 26
) (
   input  logic                           clock,
   input  logic                           reset,
   input  nsa_pkg::stk_ctrl_type          ctrl,
   input  logic [ENTRY_W-1:0]             push_data,
   output logic [$clog2(DEPTH+1)-1:0]     count,
   output logic [ENTRY_W-1:0]             top_entry
);

   localparam int unsigned CNT_W = $clog2(DEPTH+1);
   localparam int unsigned IDX_W = $clog2(DEPTH);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [CNT_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] top_ff;

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Read the entry that becomes the top after this cycle.
   assign rd_addr = count_in - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[count_ff[IDX_W-1:0]] <= push_data;
      end
   end

   // Bypass the pushed entry; otherwise read the new top from memory.
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         top_ff <= push_data;
      end else begin
         top_ff <= mem[rd_addr[IDX_W-1:0]];
      end
   end

   assign count     = count_ff;
   assign top_entry = top_ff;

endmodule

[rtl/core/nested_stack_allocator_top.sv]
`timescale 1ns / 1ps

// Nested (LIFO) arena allocator bookkeeping with heap spill. Each request is
// allocate, free-top or grow (other opcodes report totals only); each gives
// exactly one response carrying status, block offset/size/spill flag and the
// running totals and capacity. Requests are taken one per clock while the
// response side is not stalled: a request is held in the input register, is
// resolved in one pass against the allocator state, and its response is
// captured in the output register. Top offset, totals and entry count are
// all updated as each request is resolved. The entry stack is a memory whose
// top entry is pre-read into a register, so a free can follow a push or pop
// back to back. No clearing pass is needed after reset. Writing
// initial_capacity loads the capacity at once; write it only while no request
// is outstanding. Totals and grown capacity saturate at 0xFFFFFFFF.
module nested_stack_allocator_top #(
   parameter int unsigned STACK_DEPTH = 32,
   parameter int unsigned SIZE_BITS   = 25
) (
   input  logic       clock,
   input  logic       reset,
   nsa_req_if.sink    req_chan,
   nsa_rsp_if.source  rsp_chan,
   nsa_csr_if.sink    csr_chan
);

   localparam int unsigned WORD_W  = nsa_pkg::WORD_W;
   localparam int unsigned ENTRY_W = SIZE_BITS + 1;
   localparam int unsigned CNT_W   = $clog2(STACK_DEPTH + 1);

   // Largest granule-aligned size that still fits in SIZE_BITS.
   localparam logic [SIZE_BITS:0] SIZE_LIMIT =
      {1'b0, ~SIZE_BITS'(nsa_pkg::ALIGN_MASK)};

   // ---------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------
   logic                  in_valid_ff;
   nsa_pkg::op_type       in_op_ff;
   logic [SIZE_BITS-1:0]  in_size_ff;
   logic [WORD_W-1:0]     in_rel_ff;

   // Output register
   logic                  out_valid_ff;
   nsa_pkg::status_type   out_status_ff;
   logic [WORD_W-1:0]     out_offset_ff;
   logic                  out_spill_ff;
   logic [SIZE_BITS-1:0]  out_size_ff;
   logic [WORD_W-1:0]     out_total_ff;
   logic [WORD_W-1:0]     out_peak_ff;
   logic [WORD_W-1:0]     out_cap_ff;

   // Allocator state
   logic [WORD_W-1:0]     top_ff,   top_in;
   logic [WORD_W-1:0]     alloc_ff, alloc_in;
   logic [WORD_W-1:0]     peak_ff,  peak_in;
   logic [WORD_W-1:0]     cap_ff,   cap_in;

   logic                  fire;
   logic                  req_take;

   // Entry stack
   nsa_pkg::stk_ctrl_type stk_ctrl;
   logic [ENTRY_W-1:0]    stk_push_data;
   logic [CNT_W-1:0]      stk_count;
   logic [ENTRY_W-1:0]    stk_top;

   // Resolve-stage signals
   logic [SIZE_BITS-1:0]  req_minus1;
   logic [SIZE_BITS:0]    rnd_sum;
   logic [SIZE_BITS-1:0]  rnd_size;
   logic [WORD_W-1:0]     rnd_word;
   logic [WORD_W:0]       fit_sum;
   logic                  alloc_spill;
   logic [WORD_W:0]       alloc_sum;
   logic [WORD_W-1:0]     alloc_sat;
   logic                  top_spill;
   logic [SIZE_BITS-1:0]  top_size;
   logic [WORD_W-1:0]     top_size_word;
   logic [WORD_W-1:0]     free_offs;
   logic [WORD_W:0]       grow_sum;
   logic                  stack_full;
   logic                  stack_empty;

   nsa_pkg::status_type   res_status;
   logic [WORD_W-1:0]     res_offset;
   logic                  res_spill;
   logic [SIZE_BITS-1:0]  res_size;

   // Advance the resolve stage when the output register is free or draining.
   assign fire     = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || fire;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   // Hold the request payload until it is resolved.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= nsa_pkg::op_type'(req_chan.operation);
         in_size_ff <= req_chan.request_size;
         in_rel_ff  <= req_chan.release_offset;
      end
   end

   // ---------------------------------------------------------------------
   // Entry stack: {spill flag, rounded size} per live allocation
   // ---------------------------------------------------------------------
   nsa_entry_stack #(
      .DEPTH   (STACK_DEPTH),
      .ENTRY_W (ENTRY_W)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (stk_ctrl),
      .push_data (stk_push_data),
      .count     (stk_count),
      .top_entry (stk_top)
   );

   assign stack_full  = (stk_count >= CNT_W'(STACK_DEPTH));
   assign stack_empty = (stk_count == '0);

   // ---------------------------------------------------------------------
   // Size rounding: up to the next 32-byte multiple, zero stays zero,
   // clamp to the largest aligned size that fits.
   // ---------------------------------------------------------------------
   assign req_minus1 = in_size_ff - SIZE_BITS'(1);
   assign rnd_sum    = {1'b0, req_minus1 | SIZE_BITS'(nsa_pkg::ALIGN_MASK)}
                       + (SIZE_BITS+1)'(1);

   always_comb begin
      if (in_size_ff == '0) begin
         rnd_size = '0;
      end else if (rnd_sum > SIZE_LIMIT) begin
         rnd_size = SIZE_LIMIT[SIZE_BITS-1:0];
      end else begin
         rnd_size = rnd_sum[SIZE_BITS-1:0];
      end
   end

   assign rnd_word = WORD_W'(rnd_size);

   // Allocate: place at top if it fits under capacity, else spill to heap.
   assign fit_sum     = {1'b0, top_ff} + {1'b0, rnd_word};
   assign alloc_spill = (fit_sum > {1'b0, cap_ff});
   assign alloc_sum   = {1'b0, alloc_ff} + {1'b0, rnd_word};
   assign alloc_sat   = alloc_sum[WORD_W] ? nsa_pkg::WORD_MAX : alloc_sum[WORD_W-1:0];

   // Free: the top entry's expected offset is the top minus its size.
   assign top_spill     = stk_top[SIZE_BITS];
   assign top_size      = stk_top[SIZE_BITS-1:0];
   assign top_size_word = WORD_W'(top_size);
   assign free_offs     = top_ff - top_size_word;

   // Grow: 1.5 times the high-water mark.
   assign grow_sum = {1'b0, peak_ff} + {2'b00, peak_ff[WORD_W-1:1]};

   always_comb begin
      res_status    = nsa_pkg::ST_OK;
      res_offset    = '0;
      res_spill     = 1'b0;
      res_size      = '0;
      top_in        = top_ff;
      alloc_in      = alloc_ff;
      peak_in       = peak_ff;
      cap_in        = cap_ff;
      stk_ctrl.push = 1'b0;
      stk_ctrl.pop  = 1'b0;
      stk_push_data = {alloc_spill, rnd_size};

      case (in_op_ff)
         nsa_pkg::OP_ALLOC: begin
            if (stack_full) begin
               res_status = nsa_pkg::ST_FULL;
            end else begin
               res_size      = rnd_size;
               res_spill     = alloc_spill;
               stk_ctrl.push = fire;
               if (!alloc_spill) begin
                  res_offset = top_ff;
                  top_in     = fit_sum[WORD_W-1:0];
               end
               alloc_in = alloc_sat;
               if (alloc_sat > peak_ff) begin
                  peak_in = alloc_sat;
               end
            end
         end
         nsa_pkg::OP_FREE: begin
            if (stack_empty) begin
               res_status = nsa_pkg::ST_EMPTY;
            end else begin
               res_size  = top_size;
               res_spill = top_spill;
               if (!top_spill) begin
                  res_offset = free_offs;
               end
               if (!top_spill && (in_rel_ff != free_offs)) begin
                  res_status = nsa_pkg::ST_MISMATCH;
               end else begin
                  // Drop the top entry and rewind; totals floor at zero.
                  stk_ctrl.pop = fire;
                  if (!top_spill) begin
                     top_in = free_offs;
                  end
                  alloc_in = (alloc_ff > top_size_word) ? (alloc_ff - top_size_word) : '0;
               end
            end
         end
         nsa_pkg::OP_GROW: begin
            if (alloc_ff != '0) begin
               res_status = nsa_pkg::ST_BUSY;
            end else if (peak_ff > cap_ff) begin
               cap_in = grow_sum[WORD_W] ? nsa_pkg::WORD_MAX : grow_sum[WORD_W-1:0];
            end
         end
         default: begin
            // Unused opcode: report totals only.
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // State update
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= '0;
         alloc_ff <= '0;
         peak_ff  <= '0;
         cap_ff   <= nsa_pkg::CAP_RESET;
      end else begin
         if (fire) begin
            top_ff   <= top_in;
            alloc_ff <= alloc_in;
            peak_ff  <= peak_in;
         end
         if (csr_chan.valid) begin
            cap_ff <= csr_chan.initial_capacity;
         end else if (fire) begin
            cap_ff <= cap_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_status_ff <= res_status;
         out_offset_ff <= res_offset;
         out_spill_ff  <= res_spill;
         out_size_ff   <= res_size;
         out_total_ff  <= alloc_in;
         out_peak_ff   <= peak_in;
         out_cap_ff    <= cap_in;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.status           = out_status_ff;
   assign rsp_chan.offset           = out_offset_ff;
   assign rsp_chan.spilled          = out_spill_ff;
   assign rsp_chan.block_size       = out_size_ff;
   assign rsp_chan.total_allocated  = out_total_ff;
   assign rsp_chan.peak_allocated   = out_peak_ff;
   assign rsp_chan.current_capacity = out_cap_ff;

endmodule
